>>> hw/rtl/svm_pkg.sv
// Shared types, constants and helpers of the stack virtual machine step block.
package svm_pkg;

  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned PC_W      = 14;
  localparam int unsigned SP_W      = 15;

  typedef struct packed {
    logic        mode;
    logic [11:0] word_addr;
    logic [31:0] word_value;
  } svm_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [31:0]     acc;
    logic [PC_W-1:0] prog_counter;
    logic [SP_W-1:0] stack_ptr;
    logic [31:0]     exit_value;
    logic [5:0]      trap_opcode;
  } svm_out_t;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EXIT   = 3'd1;
  localparam logic [2:0] ST_TRAP   = 3'd2;
  localparam logic [2:0] ST_UNK    = 3'd3;
  localparam logic [2:0] ST_DIV0   = 3'd4;
  localparam logic [2:0] ST_HALTED = 3'd5;

  localparam logic CFG_ENTRY = 1'b0;
  localparam logic CFG_STACK = 1'b1;

  localparam logic [5:0] OP_LEA  = 6'd0;
  localparam logic [5:0] OP_IMM  = 6'd1;
  localparam logic [5:0] OP_JMP  = 6'd2;
  localparam logic [5:0] OP_CALL = 6'd3;
  localparam logic [5:0] OP_JZ   = 6'd4;
  localparam logic [5:0] OP_JNZ  = 6'd5;
  localparam logic [5:0] OP_ENT  = 6'd6;
  localparam logic [5:0] OP_ADJ  = 6'd7;
  localparam logic [5:0] OP_LEV  = 6'd8;
  localparam logic [5:0] OP_LI   = 6'd9;
  localparam logic [5:0] OP_LC   = 6'd10;
  localparam logic [5:0] OP_SI   = 6'd11;
  localparam logic [5:0] OP_SC   = 6'd12;
  localparam logic [5:0] OP_PUSH = 6'd13;
  localparam logic [5:0] OP_OR   = 6'd14;
  localparam logic [5:0] OP_XOR  = 6'd15;
  localparam logic [5:0] OP_AND  = 6'd16;
  localparam logic [5:0] OP_EQ   = 6'd17;
  localparam logic [5:0] OP_NE   = 6'd18;
  localparam logic [5:0] OP_LT   = 6'd19;
  localparam logic [5:0] OP_GT   = 6'd20;
  localparam logic [5:0] OP_LE   = 6'd21;
  localparam logic [5:0] OP_GE   = 6'd22;
  localparam logic [5:0] OP_SHL  = 6'd23;
  localparam logic [5:0] OP_SHR  = 6'd24;
  localparam logic [5:0] OP_ADD  = 6'd25;
  localparam logic [5:0] OP_SUB  = 6'd26;
  localparam logic [5:0] OP_MUL  = 6'd27;
  localparam logic [5:0] OP_DIV  = 6'd28;
  localparam logic [5:0] OP_MOD  = 6'd29;
  localparam logic [5:0] OP_OPEN = 6'd30;
  localparam logic [5:0] OP_MCMP = 6'd36;
  localparam logic [5:0] OP_EXIT = 6'd37;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FOP, PH_FIMM, PH_EX, PH_RD, PH_RD2, PH_DIV, PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   accept;
  } svm_cmd_t;

  typedef struct packed {
    logic halted;
    logic needs_read;
    logic needs_rd2;
    logic div_go;
    logic div_last;
  } svm_stat_t;

  function automatic logic [MEM_AW-1:0] mem_idx(input logic [31:0] byte_addr);
    return MEM_AW'(byte_addr >> 2);
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

endpackage

>>> hw/rtl/svm_ctrl.sv
// Sequencer of the stack machine: walks fetch, execute, operand and divide phases.
module svm_ctrl import svm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      mode_i,
  input  svm_stat_t stat_i,
  output svm_cmd_t  cmd_o,
  output logic      busy,
  output logic      done_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_FOP, S_FIMM, S_EX, S_RD, S_RD2, S_DIV, S_DONE
  } state_e;

  state_e state_q;
  logic   accept;

  assign busy   = (state_q != S_IDLE) && (state_q != S_DONE);
  assign accept = start && !busy;
  assign done_o = (state_q == S_DONE);

  always_comb begin
    unique case (state_q)
      S_IDLE: cmd_o.phase = PH_IDLE;
      S_FOP:  cmd_o.phase = PH_FOP;
      S_FIMM: cmd_o.phase = PH_FIMM;
      S_EX:   cmd_o.phase = PH_EX;
      S_RD:   cmd_o.phase = PH_RD;
      S_RD2:  cmd_o.phase = PH_RD2;
      S_DIV:  cmd_o.phase = PH_DIV;
      S_DONE: cmd_o.phase = PH_DONE;
      default: cmd_o.phase = PH_IDLE;
    endcase
    cmd_o.accept = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE, S_DONE: begin
          if (accept) begin
            // A memory write or a step of a halted machine finishes at once.
            state_q <= (!mode_i || stat_i.halted) ? S_DONE : S_FOP;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FOP:  state_q <= S_FIMM;
        S_FIMM: state_q <= S_EX;
        S_EX:   state_q <= stat_i.needs_read ? S_RD : S_DONE;
        S_RD: begin
          if (stat_i.needs_rd2) begin
            state_q <= S_RD2;
          end else if (stat_i.div_go) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_RD2:  state_q <= S_DONE;
        S_DIV:  state_q <= stat_i.div_last ? S_DONE : S_DIV;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  ap_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");
  ap_fetch_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FOP |=> state_q == S_FIMM) else $error("fetch order broken");
  ap_halted_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stat_i.halted |=> done_o) else $error("halted step not direct");

endmodule

>>> hw/rtl/svm_dp.sv
// Datapath of the stack machine: registers, unified memory, ALU and divider.
module svm_dp import svm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  svm_cmd_t    cmd_i,
  input  svm_in_t     in_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        cfg_ready_o,
  output svm_stat_t   stat_o,
  output svm_out_t    res_o
);

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rdata_q;
  logic [MEM_AW-1:0] raddr, waddr;
  logic [31:0] wdata;
  logic        we;

  logic [PC_W-1:0] entry_q, pc_q, pc_d;
  logic [SP_W-1:0] stop_q, sp_q, sp_d, fp_q, fp_d;
  logic [31:0]     ax_q, ax_d, exit_q, exit_d;
  logic [2:0]      status_q, status_d;
  logic [5:0]      trap_q, trap_d, op_q, op_d;
  logic            op_hi_q, op_hi_d, halted_q, halted_d;
  logic [MEM_AW-1:0] sc_idx_q, sc_idx_d;
  logic [1:0]      sc_lane_q, sc_lane_d;
  logic [31:0]     rem_q, rem_d, quo_q, quo_d;
  logic [4:0]      cnt_q, cnt_d;

  logic [SP_W-1:0] sp_m4, sp_p4, imm4;
  logic [32:0]     trial;
  logic [31:0]     rem_n, quo_n, alu, a, merged;
  logic [4:0]      sh;
  logic            is_div;

  assign cfg_ready_o = 1'b1;
  assign sp_m4 = sp_q - SP_W'(4);
  assign sp_p4 = sp_q + SP_W'(4);
  assign imm4  = {rdata_q[SP_W-3:0], 2'b00};
  assign a     = rdata_q;
  assign is_div = !op_hi_q && (op_q == OP_DIV || op_q == OP_MOD);

  // One restoring divide step per cycle.
  assign trial = {rem_q, quo_q[31]} - {1'b0, ax_q};
  assign rem_n = trial[32] ? {rem_q[30:0], quo_q[31]} : trial[31:0];
  assign quo_n = {quo_q[30:0], !trial[32]};

  assign sh     = {sc_lane_q, 3'b000};
  assign merged = (rdata_q & ~(32'hFF << sh)) | (32'(ax_q[7:0]) << sh);

  always_comb begin
    unique case (op_q)
      OP_OR:  alu = a | ax_q;
      OP_XOR: alu = a ^ ax_q;
      OP_AND: alu = a & ax_q;
      OP_EQ:  alu = 32'(a == ax_q);
      OP_NE:  alu = 32'(a != ax_q);
      OP_LT:  alu = 32'(a < ax_q);
      OP_GT:  alu = 32'(a > ax_q);
      OP_LE:  alu = 32'(a <= ax_q);
      OP_GE:  alu = 32'(a >= ax_q);
      OP_SHL: alu = (|ax_q[31:5]) ? 32'd0 : (a << ax_q[4:0]);
      OP_SHR: alu = (|ax_q[31:5]) ? 32'd0 : (a >> ax_q[4:0]);
      OP_ADD: alu = a + ax_q;
      OP_SUB: alu = a - ax_q;
      OP_MUL: alu = a * ax_q;
      default: alu = ax_q;
    endcase
  end

  always_comb begin
    stat_o.halted     = halted_q;
    stat_o.needs_read = !op_hi_q && ((op_q >= OP_LEV && op_q <= OP_MOD && op_q != OP_PUSH)
                        || op_q == OP_EXIT);
    stat_o.needs_rd2  = !op_hi_q && (op_q == OP_LEV || op_q == OP_SC);
    stat_o.div_go     = is_div && (ax_q != 32'd0);
    stat_o.div_last   = (cnt_q == 5'd31);
  end

  always_comb begin
    unique case (cmd_i.phase)
      PH_EX: begin
        if (!op_hi_q && op_q == OP_LEV) begin
          raddr = mem_idx(32'(fp_q));
        end else if (!op_hi_q && (op_q == OP_LI || op_q == OP_LC)) begin
          raddr = mem_idx(ax_q);
        end else begin
          raddr = mem_idx(32'(sp_q));
        end
      end
      PH_RD: raddr = (op_q == OP_SC) ? mem_idx(rdata_q) : mem_idx(32'(sp_p4));
      default: raddr = mem_idx(32'(pc_q));
    endcase
  end

  always_comb begin
    pc_d = pc_q; sp_d = sp_q; fp_d = fp_q; ax_d = ax_q;
    exit_d = exit_q; status_d = status_q; trap_d = trap_q;
    op_d = op_q; op_hi_d = op_hi_q; halted_d = halted_q;
    sc_idx_d = sc_idx_q; sc_lane_d = sc_lane_q;
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    we = 1'b0; waddr = mem_idx(32'(sp_m4)); wdata = ax_q;

    if (cmd_i.accept) begin
      exit_d = '0; trap_d = '0; status_d = ST_OK;
      if (!in_i.mode) begin
        we = 1'b1; waddr = MEM_AW'(in_i.word_addr); wdata = in_i.word_value;
        pc_d = entry_q; sp_d = stop_q; fp_d = stop_q; ax_d = '0; halted_d = 1'b0;
      end else if (halted_q) begin
        status_d = ST_HALTED;
      end
    end else begin
      unique case (cmd_i.phase)
        PH_FOP: pc_d = pc_q + PC_W'(4);
        PH_FIMM: begin
          op_d    = rdata_q[5:0];
          op_hi_d = |rdata_q[31:6];
          if (rdata_q < 32'(OP_LEV)) begin
            pc_d = pc_q + PC_W'(4);
          end
        end
        PH_EX: begin
          if (op_hi_q || op_q > OP_EXIT) begin
            status_d = ST_UNK; trap_d = op_q; halted_d = 1'b1;
          end else if (op_q >= OP_OPEN && op_q <= OP_MCMP) begin
            status_d = ST_TRAP; trap_d = op_q;
          end else begin
            unique case (op_q)
              OP_LEA: ax_d = 32'(fp_q) + {rdata_q[29:0], 2'b00};
              OP_IMM: ax_d = rdata_q;
              OP_JMP: pc_d = rdata_q[PC_W-1:0];
              OP_CALL: begin
                sp_d = sp_m4; we = 1'b1; wdata = 32'(pc_q);
                pc_d = rdata_q[PC_W-1:0];
              end
              OP_JZ:  if (ax_q == 32'd0) pc_d = rdata_q[PC_W-1:0];
              OP_JNZ: if (ax_q != 32'd0) pc_d = rdata_q[PC_W-1:0];
              OP_ENT: begin
                we = 1'b1; wdata = 32'(fp_q);
                fp_d = sp_m4; sp_d = sp_m4 - imm4;
              end
              OP_ADJ:  sp_d = sp_q + imm4;
              OP_LEV:  sp_d = fp_q;
              OP_PUSH: begin
                sp_d = sp_m4; we = 1'b1; wdata = ax_q;
              end
              default: ;
            endcase
          end
        end
        PH_RD: begin
          unique case (op_q)
            OP_LEV: begin
              fp_d = rdata_q[SP_W-1:0]; sp_d = sp_p4;
            end
            OP_LI: ax_d = rdata_q;
            OP_LC: ax_d = sext8(8'(rdata_q >> {ax_q[1:0], 3'b000}));
            OP_SI: begin
              sp_d = sp_p4; we = 1'b1; waddr = mem_idx(rdata_q); wdata = ax_q;
            end
            OP_SC: begin
              sp_d = sp_p4; sc_idx_d = mem_idx(rdata_q); sc_lane_d = rdata_q[1:0];
            end
            OP_DIV, OP_MOD: begin
              sp_d = sp_p4;
              if (ax_q == 32'd0) begin
                status_d = ST_DIV0; halted_d = 1'b1;
              end else begin
                rem_d = '0; quo_d = rdata_q; cnt_d = '0;
              end
            end
            OP_EXIT: begin
              status_d = ST_EXIT; exit_d = rdata_q; halted_d = 1'b1;
            end
            default: begin
              sp_d = sp_p4; ax_d = alu;
            end
          endcase
        end
        PH_RD2: begin
          if (op_q == OP_LEV) begin
            pc_d = rdata_q[PC_W-1:0]; sp_d = sp_p4;
          end else begin
            we = 1'b1; waddr = sc_idx_q; wdata = merged;
            ax_d = sext8(ax_q[7:0]);
          end
        end
        PH_DIV: begin
          rem_d = rem_n; quo_d = quo_n; cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            ax_d = (op_q == OP_DIV) ? quo_n : rem_n;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; op_hi_q <= op_hi_d;
    sc_idx_q <= sc_idx_d; sc_lane_q <= sc_lane_d;
    rem_q <= rem_d; quo_q <= quo_d; exit_q <= exit_d; trap_q <= trap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0; stop_q <= SP_W'(16384);
      pc_q <= '0; sp_q <= SP_W'(16384); fp_q <= SP_W'(16384);
      ax_q <= '0; halted_q <= 1'b0; status_q <= ST_OK; cnt_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ENTRY: entry_q <= cfg_data_i[PC_W-1:0];
          CFG_STACK: stop_q  <= cfg_data_i[SP_W-1:0];
          default: ;
        endcase
      end
      pc_q <= pc_d; sp_q <= sp_d; fp_q <= fp_d; ax_q <= ax_d;
      halted_q <= halted_d; status_q <= status_d; cnt_q <= cnt_d;
    end
  end

  always_comb begin
    res_o.status       = status_q;
    res_o.acc          = ax_q;
    res_o.prog_counter = pc_q;
    res_o.stack_ptr    = sp_q;
    res_o.exit_value   = exit_q;
    res_o.trap_opcode  = trap_q;
  end

  ap_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && !in_i.mode |=> !halted_q && ax_q == 32'd0)
    else $error("write did not re-arm");
  ap_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.phase == PH_DIV |-> ax_q != 32'd0) else $error("divide by zero in divider");
  ap_halted_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && in_i.mode && halted_q |=> status_q == ST_HALTED && $stable(pc_q))
    else $error("halted step changed state");

endmodule

>>> hw/rtl/stack_vm_instruction_step.sv
// Top level of the stack virtual machine step block.
//  channel   direction  handshake                 payload
//  command   in         start, busy               in_i (svm_in_t)
//  result    out        done_o strobe, one cycle  res_o (svm_out_t)
//  config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
// A memory write or a step of a halted machine raises the result strobe in the next cycle.
// An instruction walks opcode read, immediate read, execute and up to two operand reads
// through the single read port of the memory; DIV and MOD then add the steps of the
// one-bit-per-cycle divider. A new command may transfer in the cycle done_o is high.
// The receiver cannot hold a result off, so the block never stalls on the result side.
// Reset leaves pc at 0, sp and bp at 16384, the accumulator cleared and the machine armed.
module stack_vm_instruction_step import svm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  svm_in_t     in_i,
  output logic        done_o,
  output svm_out_t    res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  svm_cmd_t  cmd;
  svm_stat_t stat;

  svm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (in_i.mode),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  svm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_o      (stat),
    .res_o       (res_o)
  );

endmodule

>>> bench/tb.sv
// Self-checking testbench for the stack virtual machine step block.
module tb;
  import svm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE      = 48;

  // Tracks the machine state and the results still due from the block.
  class svm_step_tracker;
    logic [31:0]     mem [MEM_WORDS];
    logic [PC_W-1:0] pc;
    logic [SP_W-1:0] sp;
    logic [SP_W-1:0] bp;
    logic [31:0]     ax;
    logic            halted;
    logic [PC_W-1:0] entry;
    logic [SP_W-1:0] stack_top;
    svm_out_t        due_results[$];
    int unsigned     mismatches;

    function new();
      foreach (mem[i]) mem[i] = '0;
      entry      = '0;
      stack_top  = SP_W'(16384);
      mismatches = 0;
      rearm();
    endfunction

    function void rearm();
      pc     = entry;
      sp     = stack_top;
      bp     = stack_top;
      ax     = '0;
      halted = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == CFG_ENTRY) entry = value[PC_W-1:0];
      else stack_top = value[SP_W-1:0];
    endfunction

    function logic [31:0] rd(logic [31:0] addr);
      return mem[addr[13:2]];
    endfunction

    function logic [31:0] fetch();
      logic [31:0] v;
      v  = mem[pc[13:2]];
      pc = pc + PC_W'(4);
      return v;
    endfunction

    function logic [31:0] pop();
      logic [31:0] v;
      v  = mem[sp[13:2]];
      sp = sp + SP_W'(4);
      return v;
    endfunction

    function void push(logic [31:0] v);
      sp = sp - SP_W'(4);
      mem[sp[13:2]] = v;
    endfunction

    function void note_item(svm_in_t x);
      svm_out_t    r;
      logic [31:0] op, imm, a, w;
      logic [7:0]  b;
      int          sh;
      r = '0;
      if (!x.mode) begin
        mem[x.word_addr] = x.word_value;
        rearm();
      end else if (halted) begin
        r.status = ST_HALTED;
      end else begin
        op = fetch();
        case (op)
          32'(OP_LEA): begin imm = fetch(); ax = 32'(bp) + imm * 4; end
          32'(OP_IMM): ax = fetch();
          32'(OP_JMP): begin imm = fetch(); pc = imm[PC_W-1:0]; end
          32'(OP_CALL): begin
            imm = fetch();
            push(32'(pc));
            pc = imm[PC_W-1:0];
          end
          32'(OP_JZ): begin imm = fetch(); if (ax == 0) pc = imm[PC_W-1:0]; end
          32'(OP_JNZ): begin imm = fetch(); if (ax != 0) pc = imm[PC_W-1:0]; end
          32'(OP_ENT): begin
            imm = fetch();
            push(32'(bp));
            bp = sp;
            sp = SP_W'(32'(sp) - imm * 4);
          end
          32'(OP_ADJ): begin imm = fetch(); sp = SP_W'(32'(sp) + imm * 4); end
          32'(OP_LEV): begin
            sp = bp;
            bp = SP_W'(pop());
            pc = PC_W'(pop());
          end
          32'(OP_LI): ax = rd(ax);
          32'(OP_LC): begin
            sh = ax[1:0] * 8;
            w  = rd(ax) >> sh;
            b  = w[7:0];
            ax = {{24{b[7]}}, b};
          end
          32'(OP_SI): begin a = pop(); mem[a[13:2]] = ax; end
          32'(OP_SC): begin
            a  = pop();
            sh = a[1:0] * 8;
            w  = rd(a);
            w  = (w & ~(32'hFF << sh)) | ((ax & 32'hFF) << sh);
            mem[a[13:2]] = w;
            ax = {{24{ax[7]}}, ax[7:0]};
          end
          32'(OP_PUSH): push(ax);
          32'(OP_OR):  ax = pop() | ax;
          32'(OP_XOR): ax = pop() ^ ax;
          32'(OP_AND): ax = pop() & ax;
          32'(OP_EQ):  ax = 32'(pop() == ax);
          32'(OP_NE):  ax = 32'(pop() != ax);
          32'(OP_LT):  ax = 32'(pop() < ax);
          32'(OP_GT):  ax = 32'(pop() > ax);
          32'(OP_LE):  ax = 32'(pop() <= ax);
          32'(OP_GE):  ax = 32'(pop() >= ax);
          32'(OP_SHL): begin a = pop(); ax = (ax >= 32) ? '0 : a << ax; end
          32'(OP_SHR): begin a = pop(); ax = (ax >= 32) ? '0 : a >> ax; end
          32'(OP_ADD): ax = pop() + ax;
          32'(OP_SUB): ax = pop() - ax;
          32'(OP_MUL): ax = pop() * ax;
          32'(OP_DIV), 32'(OP_MOD): begin
            a = pop();
            if (ax == 0) begin
              r.status = ST_DIV0;
              halted   = 1'b1;
            end else begin
              ax = (op == 32'(OP_DIV)) ? a / ax : a % ax;
            end
          end
          32'(OP_EXIT): begin
            r.status     = ST_EXIT;
            r.exit_value = mem[sp[13:2]];
            halted       = 1'b1;
          end
          default: begin
            r.trap_opcode = op[5:0];
            if (op >= 32'(OP_OPEN) && op <= 32'(OP_MCMP)) begin
              r.status = ST_TRAP;
            end else begin
              r.status = ST_UNK;
              halted   = 1'b1;
            end
          end
        endcase
      end
      r.acc          = ax;
      r.prog_counter = pc;
      r.stack_ptr    = sp;
      due_results.push_back(r);
    endfunction

    function void check_result(svm_out_t got);
      svm_out_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status || got.acc !== want.acc ||
          got.prog_counter !== want.prog_counter || got.stack_ptr !== want.stack_ptr ||
          got.exit_value !== want.exit_value || got.trap_opcode !== want.trap_opcode) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  svm_in_t     in_i;
  logic        done_o;
  svm_out_t    res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;

  svm_step_tracker tracker;
  int unsigned     cycles;
  bit              gaps_on;

  stack_vm_instruction_step dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(res_o);
  end

  // Leaves start high so back-to-back transfers follow without a gap, unless a random gap drops it.
  task automatic send_item(svm_in_t x);
    start <= 1'b1;
    in_i  <= x;
    do @(posedge clk_i); while (busy);
    tracker.note_item(x);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic write_word(logic [11:0] addr, logic [31:0] value);
    svm_in_t x;
    x.mode       = 1'b0;
    x.word_addr  = addr;
    x.word_value = value;
    send_item(x);
  endtask

  task automatic step_once();
    svm_in_t x;
    x.mode       = 1'b1;
    x.word_addr  = 12'($urandom);
    x.word_value = $urandom;
    send_item(x);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_reg(logic idx, logic [31:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, value);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_imm(logic [5:0] op, int unsigned plen);
    logic [31:0] base;
    base = 32'(tracker.entry);
    case (op)
      OP_JMP, OP_CALL, OP_JZ, OP_JNZ: return base + 4 * $urandom_range(0, plen - 1);
      OP_ENT, OP_ADJ: return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
      default: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return $urandom_range(1, 40);
          2: return 32'hFFFF_FFFF;
          3: return $urandom_range(0, 16383);
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Loads a short program at the entry address, then runs it for a while.
  task automatic run_program(int unsigned steps);
    logic [31:0] words[$];
    logic [5:0]  op;
    int unsigned plen;
    plen = $urandom_range(3, 14);
    for (int k = 0; k < plen; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        words.push_back(($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(38, 63));
      end else begin
        op = 6'($urandom_range(0, 37));
        if (op >= OP_OPEN && op <= OP_EXIT && $urandom_range(0, 2) != 0)
          op = 6'($urandom_range(0, 29));
        words.push_back(32'(op));
        if (op <= OP_ADJ) words.push_back(pick_imm(op, plen));
      end
    end
    foreach (words[k]) write_word(12'(tracker.entry[13:2] + k), words[k]);
    repeat (steps) step_once();
  endtask

  initial begin
    int unsigned items;
    tracker     = new();
    cycles      = 0;
    gaps_on     = 1'b1;
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ENTRY;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every word gets a defined value before any instruction runs.
    for (int i = 0; i < MEM_WORDS; i++) write_word(12'(i), $urandom);

    // Divide by zero, then a step while halted.
    write_word(12'd0, 32'(OP_IMM));
    write_word(12'd1, 32'hFFFF_FFFF);
    write_word(12'd2, 32'(OP_PUSH));
    write_word(12'd3, 32'(OP_IMM));
    write_word(12'd4, 32'h0);
    write_word(12'd5, 32'(OP_DIV));
    repeat (5) step_once();
    // Builtins and exit, then a step while halted.
    set_reg(CFG_ENTRY, 32'hFFFF_0018);
    write_word(12'd6, 32'(OP_OPEN));
    write_word(12'd7, 32'(OP_MCMP));
    write_word(12'd8, 32'(OP_EXIT));
    write_word(12'd9, 32'hFFFF_FFFF);
    repeat (4) step_once();
    set_reg(CFG_ENTRY, 32'h0000_3FFF);
    set_reg(CFG_STACK, 32'h0000_0000);
    write_word(12'hFFF, 32'(OP_PUSH));
    step_once();
    step_once();

    items = 0;
    while (items < 1150) begin
      if (items <= 1000 && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: set_reg(CFG_ENTRY, 32'({$urandom, 14'h0} | 32'(4 * $urandom_range(0, 4095))));
          1: set_reg(CFG_ENTRY, $urandom);
          2: set_reg(CFG_STACK, ($urandom_range(0, 1) == 1) ? 32'h4000 : $urandom);
          default: set_reg(CFG_STACK,
                           32'({$urandom, 15'h0} | 32'(4 * $urandom_range(0, 8191))));
        endcase
      end
      if (items <= 1000 && $urandom_range(0, 15) == 0) drain();
      if (items > 1000) gaps_on = 1'b0;
      run_program($urandom_range(3, 16));
      if ($urandom_range(0, 5) == 0) write_word(12'($urandom), $urandom);
      items += 20;
    end

    drain();
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
